[sv/hsv_to_rgb_converter_defines.svh]
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define H2R_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("h2r: implication check failed");

// Implication with a fixed cycle delay, disabled while in reset.
`define H2R_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##dly (cons)) \
    else $error("h2r: delayed check failed");

`endif

[sv/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int unsigned HUE_W        = 16;  // hue port width
  localparam int unsigned CH_W         = 8;   // color channel width
  localparam int unsigned HUE_BITS_DEF = 16;  // default hue fraction bits
  localparam int unsigned PIPE_LAT     = 6;   // request to result, in cycles

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for any 16-bit x
  localparam logic [15:0] RECIP_255   = 16'd32897;
  localparam int unsigned RECIP_SHIFT = 23;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  typedef struct packed {
    logic    valid;
    sector_e sector;
  } ctl_t;

endpackage

[sv/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fully pipelined HSV to RGB color conversion, one pixel per clock.
// ----------------------------------------------------------------------------
// Takes one request per clock: busy_o is never raised, so start_i may stay
// high every cycle. Each request yields one RGB result, shown for one cycle
// with done_o; the receiver cannot stall and must take it then. The six
// register stages are hue times six with V*(1-S); f*S, (1-f)*S and the
// divide by 255 for p; V*f*S and V*(1-f)*S; the rounding add; the divide by
// 255 for q and t as reciprocal multiplies; and the sector table. That stage
// count sets the latency.
// Hue bits above HUE_BITS are ignored; results match truncation toward zero.
module hsv_to_rgb_converter #(
  parameter int unsigned HUE_BITS = h2r_pkg::HUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [h2r_pkg::HUE_W-1:0] hue_i,
  input  logic [h2r_pkg::CH_W-1:0]  saturation_i,
  input  logic [h2r_pkg::CH_W-1:0]  brightness_i,
  output logic                      done_o,
  output logic [h2r_pkg::CH_W-1:0]  red_o,
  output logic [h2r_pkg::CH_W-1:0]  green_o,
  output logic [h2r_pkg::CH_W-1:0]  blue_o
);
  import h2r_pkg::*;

  logic                req_w;
  ctl_t                s1_ctl, s5_ctl;
  logic [HUE_BITS-1:0] s1_frac;
  logic [CH_W-1:0]     s1_sat, s1_val;
  logic [2*CH_W-1:0]   s1_pnum;
  logic [CH_W-1:0]     s5_val, s5_p, s5_dq, s5_dt;

  assign busy_o = 1'b0;
  assign req_w  = start_i & ~busy_o;

  h2r_sector #(
    .HUE_BITS(HUE_BITS)
  ) u_sector (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_w),
    .hue_i  (hue_i),
    .sat_i  (saturation_i),
    .val_i  (brightness_i),
    .ctl_o  (s1_ctl),
    .frac_o (s1_frac),
    .sat_o  (s1_sat),
    .val_o  (s1_val),
    .pnum_o (s1_pnum)
  );

  h2r_scale #(
    .HUE_BITS(HUE_BITS)
  ) u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (s1_ctl),
    .frac_i (s1_frac),
    .sat_i  (s1_sat),
    .val_i  (s1_val),
    .pnum_i (s1_pnum),
    .ctl_o  (s5_ctl),
    .val_o  (s5_val),
    .p_o    (s5_p),
    .dq_o   (s5_dq),
    .dt_o   (s5_dt)
  );

  h2r_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s5_ctl),
    .val_i   (s5_val),
    .p_i     (s5_p),
    .dq_i    (s5_dq),
    .dt_i    (s5_dt),
    .done_o  (done_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

endmodule

[sv/h2r_sector.sv]
// ----------------------------------------------------------------------------
// h2r_sector
// First stage: hue times six into sector and fraction, p numerator.
// ----------------------------------------------------------------------------
module h2r_sector #(
  parameter int unsigned HUE_BITS = h2r_pkg::HUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_i,
  input  logic [h2r_pkg::HUE_W-1:0]  hue_i,
  input  logic [h2r_pkg::CH_W-1:0]   sat_i,
  input  logic [h2r_pkg::CH_W-1:0]   val_i,
  output h2r_pkg::ctl_t              ctl_o,
  output logic [HUE_BITS-1:0]        frac_o,
  output logic [h2r_pkg::CH_W-1:0]   sat_o,
  output logic [h2r_pkg::CH_W-1:0]   val_o,
  output logic [2*h2r_pkg::CH_W-1:0] pnum_o
);
  import h2r_pkg::*;

  logic [HUE_BITS-1:0]   hue_w;
  logic [HUE_BITS+2:0]   h6_w;
  logic [2*CH_W-1:0]     pnum_w;
  ctl_t                  ctl_d, ctl_q;
  logic [HUE_BITS-1:0]   frac_q;
  logic [CH_W-1:0]       sat_q, val_q;
  logic [2*CH_W-1:0]     pnum_q;

  // upper hue bits beyond HUE_BITS are dropped, missing ones read as zero
  assign hue_w  = HUE_BITS'(hue_i);
  assign h6_w   = ((HUE_BITS+3)'(hue_w) << 2) + ((HUE_BITS+3)'(hue_w) << 1);
  assign pnum_w = val_i * (CH_MAX - sat_i);

  assign ctl_d.valid  = req_i;
  assign ctl_d.sector = sector_e'(h6_w[HUE_BITS+2:HUE_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q <= h6_w[HUE_BITS-1:0];
    sat_q  <= sat_i;
    val_q  <= val_i;
    pnum_q <= pnum_w;
  end

  assign ctl_o  = ctl_q;
  assign frac_o = frac_q;
  assign sat_o  = sat_q;
  assign val_o  = val_q;
  assign pnum_o = pnum_q;

endmodule

[sv/h2r_scale.sv]
// ----------------------------------------------------------------------------
// h2r_scale
// Stages two to five: p, and the ceiling terms subtracted from V for q and t.
// ----------------------------------------------------------------------------
module h2r_scale #(
  parameter int unsigned HUE_BITS = h2r_pkg::HUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  h2r_pkg::ctl_t              ctl_i,
  input  logic [HUE_BITS-1:0]        frac_i,
  input  logic [h2r_pkg::CH_W-1:0]   sat_i,
  input  logic [h2r_pkg::CH_W-1:0]   val_i,
  input  logic [2*h2r_pkg::CH_W-1:0] pnum_i,
  output h2r_pkg::ctl_t              ctl_o,
  output logic [h2r_pkg::CH_W-1:0]   val_o,
  output logic [h2r_pkg::CH_W-1:0]   p_o,
  output logic [h2r_pkg::CH_W-1:0]   dq_o,
  output logic [h2r_pkg::CH_W-1:0]   dt_o
);
  import h2r_pkg::*;

  localparam int unsigned AW = HUE_BITS + CH_W;      // f*s
  localparam int unsigned YW = HUE_BITS + 2*CH_W;    // v*f*s

  // stage 2: f*s, (1-f)*s, p
  logic [HUE_BITS:0]    omf_w;
  logic [AW:0]          at_full_w;
  logic [31:0]          pprod_w;
  ctl_t                 ctl2_q;
  logic [AW-1:0]        aq2_q, at2_q;
  logic [CH_W-1:0]      val2_q, p2_q;

  // stage 3: v*f*s and v*(1-f)*s
  ctl_t                 ctl3_q;
  logic [YW-1:0]        yq3_q, yt3_q;
  logic [CH_W-1:0]      val3_q, p3_q;

  // stage 4: ceil(y / 2^HUE_BITS) + 254
  logic [YW-1:0]        rnd_w;
  logic [YW-1:0]        sq_w, st_w;
  ctl_t                 ctl4_q;
  logic [2*CH_W-1:0]    nq4_q, nt4_q;
  logic [CH_W-1:0]      val4_q, p4_q;

  // stage 5: divide by 255
  logic [31:0]          dqprod_w, dtprod_w;
  ctl_t                 ctl5_q;
  logic [CH_W-1:0]      dq5_q, dt5_q, val5_q, p5_q;

  assign omf_w     = ((HUE_BITS+1)'(1) << HUE_BITS) - (HUE_BITS+1)'(frac_i);
  assign at_full_w = omf_w * sat_i;
  assign pprod_w   = 32'(pnum_i) * 32'(RECIP_255);

  // rounding constant 255*2^HUE_BITS - 1: ceiling plus the 254 for ceil(/255)
  assign rnd_w = (YW'(CH_MAX) << HUE_BITS) - YW'(1);
  assign sq_w  = yq3_q + rnd_w;
  assign st_w  = yt3_q + rnd_w;

  assign dqprod_w = 32'(nq4_q) * 32'(RECIP_255);
  assign dtprod_w = 32'(nt4_q) * 32'(RECIP_255);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    aq2_q  <= frac_i * sat_i;
    at2_q  <= at_full_w[AW-1:0];
    val2_q <= val_i;
    p2_q   <= pprod_w[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];

    yq3_q  <= YW'(val2_q) * YW'(aq2_q);
    yt3_q  <= YW'(val2_q) * YW'(at2_q);
    val3_q <= val2_q;
    p3_q   <= p2_q;

    nq4_q  <= sq_w[YW-1:HUE_BITS];
    nt4_q  <= st_w[YW-1:HUE_BITS];
    val4_q <= val3_q;
    p4_q   <= p3_q;

    dq5_q  <= dqprod_w[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    dt5_q  <= dtprod_w[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    val5_q <= val4_q;
    p5_q   <= p4_q;
  end

  assign ctl_o = ctl5_q;
  assign val_o = val5_q;
  assign p_o   = p5_q;
  assign dq_o  = dq5_q;
  assign dt_o  = dt5_q;

endmodule

[sv/h2r_select.sv]
// ----------------------------------------------------------------------------
// h2r_select
// Last stage: q and t from V, sector table, output registers.
// ----------------------------------------------------------------------------
module h2r_select (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  h2r_pkg::ctl_t            ctl_i,
  input  logic [h2r_pkg::CH_W-1:0] val_i,
  input  logic [h2r_pkg::CH_W-1:0] p_i,
  input  logic [h2r_pkg::CH_W-1:0] dq_i,
  input  logic [h2r_pkg::CH_W-1:0] dt_i,
  output logic                     done_o,
  output logic [h2r_pkg::CH_W-1:0] red_o,
  output logic [h2r_pkg::CH_W-1:0] green_o,
  output logic [h2r_pkg::CH_W-1:0] blue_o
);
  import h2r_pkg::*;

  logic [CH_W-1:0] q_w, t_w;
  logic [CH_W-1:0] red_d, green_d, blue_d;
  logic [CH_W-1:0] red_q, green_q, blue_q;
  logic            done_q;

  // the ceiling terms never exceed V
  assign q_w = val_i - dq_i;
  assign t_w = val_i - dt_i;

  always_comb begin
    unique case (ctl_i.sector)
      SEC_RED:     begin red_d = val_i; green_d = t_w;   blue_d = p_i;   end
      SEC_YELLOW:  begin red_d = q_w;   green_d = val_i; blue_d = p_i;   end
      SEC_GREEN:   begin red_d = p_i;   green_d = val_i; blue_d = t_w;   end
      SEC_CYAN:    begin red_d = p_i;   green_d = q_w;   blue_d = val_i; end
      SEC_BLUE:    begin red_d = t_w;   green_d = p_i;   blue_d = val_i; end
      default:     begin red_d = val_i; green_d = p_i;   blue_d = q_w;   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

[sv/h2r_chk.sv]
// ----------------------------------------------------------------------------
// h2r_chk
// Port-level checker for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module h2r_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic [h2r_pkg::CH_W-1:0]  saturation_i,
  input logic [h2r_pkg::CH_W-1:0]  brightness_i,
  input logic                      done_o,
  input logic [h2r_pkg::CH_W-1:0]  red_o,
  input logic [h2r_pkg::CH_W-1:0]  green_o,
  input logic [h2r_pkg::CH_W-1:0]  blue_o
);
  import h2r_pkg::*;

  logic req_w;
  logic black_w;
  logic gray_w;

  assign req_w   = start_i && !busy_o;
  assign black_w = (red_o == '0) && (green_o == '0) && (blue_o == '0);
  assign gray_w  = (green_o == red_o) && (blue_o == red_o);

  // every request comes out after the fixed latency
  `H2R_ASSERT_DLY(a_req_done, clk_i, rst_ni, req_w, PIPE_LAT, done_o)

  // no result without a request
  `H2R_ASSERT_IMP(a_done_req, clk_i, rst_ni, done_o, $past(req_w, PIPE_LAT))

  // zero brightness gives black
  `H2R_ASSERT_IMP(a_black, clk_i, rst_ni, done_o && $past(brightness_i == '0, PIPE_LAT), black_w)

  // zero saturation gives gray at the requested brightness
  `H2R_ASSERT_IMP(a_gray, clk_i, rst_ni, done_o && $past(saturation_i == '0, PIPE_LAT),
                  gray_w && red_o == $past(brightness_i, PIPE_LAT))

endmodule

bind hsv_to_rgb_converter h2r_chk u_h2r_chk (.*);
